// ===== design/fua_pkg.sv =====
// Package for the H.264 FU-A fragment planner.
// Holds the sequencer state type, the divider status struct and the fixed
// constants. No dependencies.
package fua_pkg;

  localparam int unsigned MtuW      = 11;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned DivNumW   = SizeW + 1;

  localparam logic [MtuW-1:0] MtuReset  = 11'd1200;
  localparam logic [MtuW-1:0] MtuMin    = 11'd1200;
  localparam logic [MtuW-1:0] MtuMax    = 11'd1500;
  localparam logic [MtuW-1:0] RtpHdrLen = 11'd12;

  localparam logic [7:0] NriMask   = 8'hE0;
  localparam logic [7:0] TypeMask  = 8'h1F;
  localparam logic [7:0] FuaType   = 8'd28;
  localparam logic [7:0] FuStartB  = 8'h80;
  localparam logic [7:0] FuEndB    = 8'h40;

  localparam logic PktSingle = 1'b0;
  localparam logic PktFua    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV1 = 4'b0010,
    ST_DIV2 = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/h264_fua_fragment_planner_core.sv =====
// Top level of the H.264 FU-A fragment planner: sequencer, output register.
// Depends on fua_pkg and fua_div.
//
//  channel | valid / flow          | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid_i/in_stall_o | nal_header_i nal_size_i frame_end_i
//  out     | out_valid_o/out_stall_i | kind offset length ind hdr idx marker last
//  cfg     | cfg_we_i              | cfg_wdata_i (mtu_bytes)
//
// A NAL no larger than the MTU goes straight to emit. A fragmented NAL
// makes two passes of the 17-step shared divider (fragment count, then
// slice length), then emits one fragment per cycle while the output is not
// stalled, and returns to idle before the next item is taken.
// Reset clears the sequencer and sets the MTU to 1200. The input is stalled
// while a NAL is in work; an output stall holds the sequencer in emit.
module h264_fua_fragment_planner_core
  import fua_pkg::*;
#(
  parameter int unsigned NumW = DivNumW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MtuW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           nal_header_i,
  input  logic [SizeW-1:0]     nal_size_i,
  input  logic                 frame_end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 packet_kind_o,
  output logic [SizeW-1:0]     payload_offset_o,
  output logic [SizeW-1:0]     payload_length_o,
  output logic [7:0]           fu_ind_o,
  output logic [7:0]           fu_hdr_o,
  output logic [IdxW-1:0]      fragment_index_o,
  output logic                 marker_o,
  output logic                 last_o
);

  state_e          state_q, state_d;
  logic [MtuW-1:0] mtu_q;
  logic [MtuW-1:0] mtu_eff;
  logic [MtuW-1:0] budget;

  logic [7:0]       hdr_q;
  logic [SizeW-1:0] size_q;
  logic             fend_q;
  logic             single_q;
  logic [IdxW-1:0]  n_q;
  logic [SizeW-1:0] slice_q;
  logic [IdxW-1:0]  idx_q;
  logic [SizeW-1:0] off_q;
  logic             div_start_q, div_start_d;

  logic             ov_q;
  logic             kind_q;
  logic [SizeW-1:0] oofs_q;
  logic [SizeW-1:0] olen_q;
  logic [7:0]       oind_q;
  logic [7:0]       ohdr_q;
  logic [IdxW-1:0]  oidx_q;
  logic             omark_q;
  logic             olast_q;

  logic             in_take;
  logic             slot_free;
  logic             emit;
  logic             final_frag;
  logic [SizeW-1:0] body_len;
  logic [NumW-1:0]  div_num;
  logic [MtuW-1:0]  div_den;
  div_stat_t        div_stat;
  logic [NumW-1:0]  div_quot;
  logic [7:0]       fh;

  always_comb begin
    mtu_eff = mtu_q;
    if (mtu_q < MtuMin) mtu_eff = MtuMin;
    if (mtu_q > MtuMax) mtu_eff = MtuMax;
  end
  assign budget   = mtu_eff - RtpHdrLen;
  assign body_len = size_q - SizeW'(1);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free  = !ov_q || !out_stall_i;
  assign emit       = (state_q == ST_EMIT) && slot_free;
  assign final_frag = (idx_q == (n_q - IdxW'(1)));

  always_comb begin
    if (state_q == ST_DIV2) begin
      div_num = NumW'(body_len) + NumW'(n_q >> 1);
      div_den = MtuW'(n_q);
    end else begin
      div_num = NumW'(body_len) + NumW'(budget) - NumW'(1);
      div_den = budget;
    end
  end

  fua_div #(
    .NumW (NumW),
    .DenW (MtuW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    div_start_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if ({5'd0, nal_size_i} <= 21'(mtu_eff)) begin
            state_d = ST_EMIT;
          end else begin
            state_d     = ST_DIV1;
            div_start_d = 1'b1;
          end
        end
      end
      ST_DIV1: begin
        if (div_stat.done) begin
          state_d     = ST_DIV2;
          div_start_d = 1'b1;
        end
      end
      ST_DIV2: begin
        if (div_stat.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit && (single_q || final_frag)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_start_q <= 1'b0;
      mtu_q       <= MtuReset;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      if (cfg_we_i) mtu_q <= cfg_wdata_i;
      if (emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hdr_q    <= nal_header_i;
      size_q   <= nal_size_i;
      fend_q   <= frame_end_i;
      single_q <= ({5'd0, nal_size_i} <= 21'(mtu_eff));
      idx_q    <= '0;
      off_q    <= SizeW'(1);
    end
    if ((state_q == ST_DIV1) && div_stat.done) n_q <= div_quot[IdxW-1:0];
    if ((state_q == ST_DIV2) && div_stat.done) slice_q <= div_quot[SizeW-1:0];
    if (emit && !single_q) begin
      idx_q <= idx_q + IdxW'(1);
      off_q <= off_q + slice_q;
    end
  end

  always_comb begin
    fh = hdr_q & TypeMask;
    if (idx_q == '0) fh = fh | FuStartB;
    if (final_frag) fh = fh | FuEndB;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (single_q) begin
        kind_q  <= PktSingle;
        oofs_q  <= '0;
        olen_q  <= size_q;
        oind_q  <= '0;
        ohdr_q  <= '0;
        oidx_q  <= '0;
        omark_q <= fend_q;
        olast_q <= 1'b1;
      end else begin
        kind_q  <= PktFua;
        oofs_q  <= off_q;
        olen_q  <= final_frag ? (size_q - off_q) : slice_q;
        oind_q  <= (hdr_q & NriMask) | FuaType;
        ohdr_q  <= fh;
        oidx_q  <= idx_q;
        omark_q <= final_frag && fend_q;
        olast_q <= final_frag;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign packet_kind_o    = kind_q;
  assign payload_offset_o = oofs_q;
  assign payload_length_o = olen_q;
  assign fu_ind_o         = oind_q;
  assign fu_hdr_o         = ohdr_q;
  assign fragment_index_o = oidx_q;
  assign marker_o         = omark_q;
  assign last_o           = olast_q;

endmodule

// ===== design/fua_div.sv =====
// Restoring divider, one quotient bit per cycle through one subtractor.
// Depends on fua_pkg.
module fua_div
  import fua_pkg::*;
#(
  parameter int unsigned NumW = DivNumW,
  parameter int unsigned DenW = MtuW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output div_stat_t       stat_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam logic [CntW-1:0] CntLoad = CntW'(NumW);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = (trial >= {1'b0, divisor_i});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CntLoad;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q - CntOne;
      if (cnt_q == CntOne) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule
